// ===== sv/ckpe_pkg.sv =====
// Shared constants, types and the key encoding for the contact key pulse encoder.
package ckpe_pkg;

  localparam int unsigned KEY_W        = 16;
  localparam int unsigned LEN_W        = 24;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned CODE_W       = 32;
  localparam int unsigned FRAME_PULSES = 72;
  localparam int unsigned START_PULSES = 8;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // register byte addresses
  localparam logic [CFG_ADDR_W-1:0] ADDR_KEY_CODE   = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SHORT_LEN  = 4'h4;
  localparam logic [CFG_ADDR_W-1:0] ADDR_LONG_LEN   = 4'h8;

  localparam logic [KEY_W-1:0] KEY_CODE_RST  = 16'd0;
  localparam logic [LEN_W-1:0] SHORT_LEN_RST = 24'd2640;
  localparam logic [LEN_W-1:0] LONG_LEN_RST  = 24'd5280;

  localparam logic [POS_W-1:0] POS_LAST        = 7'(FRAME_PULSES - 1);
  localparam logic [POS_W-1:0] POS_START_END   = 7'(START_PULSES);
  localparam logic [POS_W-1:0] POS_START_ONE   = 7'd6;

  typedef struct packed {
    logic             line_level;
    logic [LEN_W-1:0] pulse_len;
    logic             frame_end;
  } pulse_t;

  // Each 2-bit group becomes a one-cold nibble; group 0 lands in the top nibble.
  function automatic logic [CODE_W-1:0] encode_key(input logic [KEY_W-1:0] key);
    logic [CODE_W-1:0] word;
    logic [1:0]        grp;
    word = '0;
    for (int g = 0; g < 8; g++) begin
      grp = key[2*g +: 2];
      word[CODE_W-1-4*g -: 4] = ~(4'b0001 << grp);
    end
    return word;
  endfunction

endpackage

// ===== sv/ckpe_pulse_gen.sv =====
// Frame position counter and per-pulse level, length and frame end selection.
module ckpe_pulse_gen (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic                            restart,
  input  logic [ckpe_pkg::KEY_W-1:0]      key_code,
  input  logic [ckpe_pkg::LEN_W-1:0]      short_len,
  input  logic [ckpe_pkg::LEN_W-1:0]      long_len,
  output ckpe_pkg::pulse_t                pulse
);

  logic [ckpe_pkg::POS_W-1:0]  pos_r;
  logic [ckpe_pkg::POS_W-1:0]  pos_nxt;
  logic [ckpe_pkg::POS_W-1:0]  pos;
  logic [ckpe_pkg::POS_W-1:0]  data_pos;
  logic [ckpe_pkg::CODE_W-1:0] code;
  logic                        bit_val;

  assign pos      = restart ? '0 : pos_r;
  assign code     = ckpe_pkg::encode_key(key_code);
  assign data_pos = pos - ckpe_pkg::POS_START_END;

  always_comb begin
    if (pos < ckpe_pkg::POS_START_END) begin
      // start word 0,0,0,1
      bit_val = (pos >= ckpe_pkg::POS_START_ONE);
    end else begin
      bit_val = code[data_pos[5:1]];
    end
  end

  assign pulse.line_level = pos[0];
  assign pulse.pulse_len  = (bit_val != pos[0]) ? short_len : long_len;
  assign pulse.frame_end  = (pos == ckpe_pkg::POS_LAST);

  assign pos_nxt = (pos == ckpe_pkg::POS_LAST) ? '0 : pos + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== sv/contact_key_pulse_encoder.sv =====
// Top level of the contact key pulse encoder: config registers and result register.
//
// Each word on the in_ stream requests one pulse of a repeating 72-pulse frame
// for a two-wire contact key: an 8-pulse start word, then the 32 encoded key
// bits, LSB first, each bit a low pulse followed by a high pulse. Setting
// restart in a word moves the frame back to its first pulse before emitting.
// The out_ stream carries the pulse level and its length in clock ticks;
// out_tlast marks the last pulse of the frame.
// out_tvalid is registered and rises in the cycle after input accept; one word is
// taken every cycle while the receiver is ready. The result register is refilled in
// the cycle it is taken, so a stalled receiver holds out_tdata and blocks in_tready only while it stalls.
// The key code and the short and long pulse lengths are written over the APB port
// (byte addresses 0, 4, 8); the user must do so only while the stream is idle,
// as the block does not enforce it. Synchronous reset clears the frame position
// and the output valid and loads key 0, short 2640 and long 5280 ticks.
module contact_key_pulse_encoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: [0] restart, [7:1] zero
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,
  // out_tdata: [0] line_level, [24:1] pulse_len, [31:25] zero
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [31:0]                          out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [ckpe_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [ckpe_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [ckpe_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  logic [ckpe_pkg::KEY_W-1:0] key_code_r;
  logic [ckpe_pkg::LEN_W-1:0] short_len_r;
  logic [ckpe_pkg::LEN_W-1:0] long_len_r;
  logic                       cfg_wr;

  logic                       in_acc;
  ckpe_pkg::pulse_t           pulse;
  ckpe_pkg::pulse_t           res_r;
  logic                       out_valid_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_code_r  <= ckpe_pkg::KEY_CODE_RST;
      short_len_r <= ckpe_pkg::SHORT_LEN_RST;
      long_len_r  <= ckpe_pkg::LONG_LEN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr)
        ckpe_pkg::ADDR_KEY_CODE:  key_code_r  <= cfg_pwdata[ckpe_pkg::KEY_W-1:0];
        ckpe_pkg::ADDR_SHORT_LEN: short_len_r <= cfg_pwdata[ckpe_pkg::LEN_W-1:0];
        ckpe_pkg::ADDR_LONG_LEN:  long_len_r  <= cfg_pwdata[ckpe_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      ckpe_pkg::ADDR_KEY_CODE:  cfg_prdata = 32'(key_code_r);
      ckpe_pkg::ADDR_SHORT_LEN: cfg_prdata = 32'(short_len_r);
      ckpe_pkg::ADDR_LONG_LEN:  cfg_prdata = 32'(long_len_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // stream path
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  ckpe_pulse_gen u_pulse_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .restart   (in_tdata[0]),
    .key_code  (key_code_r),
    .short_len (short_len_r),
    .long_len  (long_len_r),
    .pulse     (pulse)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= pulse;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.pulse_len, res_r.line_level};
  assign out_tlast  = res_r.frame_end;

endmodule

// ===== tb/tb_contact_key_pulse_encoder.sv =====
// Self-checking testbench for the contact key pulse encoder: stream traffic, APB, predictor.
`timescale 1ns / 100ps

module tb_contact_key_pulse_encoder;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 200;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [31:0]                     out_tdata;
  logic                            out_tlast;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [ckpe_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [ckpe_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [ckpe_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  contact_key_pulse_encoder DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of registers and frame position
  logic [ckpe_pkg::KEY_W-1:0] key_val   = ckpe_pkg::KEY_CODE_RST;
  logic [ckpe_pkg::LEN_W-1:0] short_len = ckpe_pkg::SHORT_LEN_RST;
  logic [ckpe_pkg::LEN_W-1:0] long_len  = ckpe_pkg::LONG_LEN_RST;
  logic [ckpe_pkg::POS_W-1:0] frame_pos = '0;

  logic             pending_restarts[$];
  ckpe_pkg::pulse_t expected_pulses[$];

  int  mismatches  = 0;
  int  cycles      = 0;
  bit  send_idling = 1'b0;
  bit  recv_idling = 1'b0;
  int  hold_req    = 0;
  int  hold_ack    = 0;
  int  send_gap    = 0;
  int  recv_stall  = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // one-cold nibble per 2-bit group, lowest group ends up in the top nibble
  function automatic logic [31:0] key_to_code(input logic [ckpe_pkg::KEY_W-1:0] k);
    logic [3:0]  nib_of[4];
    logic [31:0] code;
    nib_of = '{4'hE, 4'hD, 4'hB, 4'h7};
    code = '0;
    for (int g = 0; g < 8; g++) code = {code[27:0], nib_of[k[2*g +: 2]]};
    return code;
  endfunction

  function automatic ckpe_pkg::pulse_t next_pulse(input logic restart);
    ckpe_pkg::pulse_t p;
    logic [6:0]       pos;
    logic             bit_val;
    logic [31:0]      code;
    if (restart || frame_pos >= ckpe_pkg::FRAME_PULSES) frame_pos = '0;
    pos = frame_pos;
    if (pos < ckpe_pkg::START_PULSES) begin
      bit_val = (pos >= 6);
    end else begin
      code = key_to_code(key_val);
      bit_val = code[(int'(pos) - ckpe_pkg::START_PULSES) >> 1];
    end
    p.line_level = pos[0];
    p.pulse_len  = (bit_val != pos[0]) ? short_len : long_len;
    p.frame_end  = (pos == ckpe_pkg::FRAME_PULSES - 1);
    frame_pos = (int'(pos) + 1 >= ckpe_pkg::FRAME_PULSES) ? '0 : pos + 7'd1;
    return p;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_contact_key_pulse_encoder NOT OK");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) expected_pulses.push_back(next_pulse(in_tdata[0]));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_restarts.size() > 0) begin
          in_tdata  <= {7'd0, pending_restarts.pop_front()};
          in_tvalid <= 1'b1;
          send_gap = send_idling ? pick_gap() : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // pulse monitor and receiver back-pressure
  always @(posedge clk) begin
    ckpe_pkg::pulse_t exp_p;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_pulses.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word level=%0b len=%0d last=%0b", $time,
                   out_tdata[0], out_tdata[24:1], out_tlast);
        end else begin
          exp_p = expected_pulses.pop_front();
          if (out_tdata[0] !== exp_p.line_level) begin
            mismatches++;
            $display("%0t: line_level expected %0b got %0b", $time,
                     exp_p.line_level, out_tdata[0]);
          end
          if (out_tdata[24:1] !== exp_p.pulse_len) begin
            mismatches++;
            $display("%0t: pulse_len expected %0d got %0d", $time,
                     exp_p.pulse_len, out_tdata[24:1]);
          end
          if (out_tlast !== exp_p.frame_end) begin
            mismatches++;
            $display("%0t: frame_end expected %0b got %0b", $time,
                     exp_p.frame_end, out_tlast);
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        recv_stall = LONG_HOLD;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_stall = recv_idling ? pick_gap() : 0;
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (pending_restarts.size() != 0 || in_tvalid || expected_pulses.size() != 0)
      @(negedge clk);
  endtask

  task automatic apb_write(input logic [ckpe_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    unique case (addr)
      ckpe_pkg::ADDR_KEY_CODE:  key_val   = value[ckpe_pkg::KEY_W-1:0];
      ckpe_pkg::ADDR_SHORT_LEN: short_len = value[ckpe_pkg::LEN_W-1:0];
      ckpe_pkg::ADDR_LONG_LEN:  long_len  = value[ckpe_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [ckpe_pkg::KEY_W-1:0] k,
                          input logic [ckpe_pkg::LEN_W-1:0] s,
                          input logic [ckpe_pkg::LEN_W-1:0] l);
    apb_write(ckpe_pkg::ADDR_KEY_CODE, {16'd0, k});
    apb_write(ckpe_pkg::ADDR_SHORT_LEN, {8'd0, s});
    apb_write(ckpe_pkg::ADDR_LONG_LEN, {8'd0, l});
  endtask

  // mostly plain running frames; restarts are rare so frames run to their end
  task automatic run_frames(input int n, input int restart_pct);
    for (int i = 0; i < n; i++)
      pending_restarts.push_back($urandom_range(99) < restart_pct);
    wait_idle();
  endtask

  initial begin
    logic directed_restarts[];
    directed_restarts = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 1,
                          0, 0, 0, 0, 0, 0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: start word, first key bits, restarts mid-frame
    foreach (directed_restarts[i]) pending_restarts.push_back(directed_restarts[i]);
    wait_idle();

    set_regs(16'hFFFF, 24'd1, 24'hFFFFFF);
    send_idling = 1'b1;
    recv_idling = 1'b1;
    run_frames(110, 2);

    // receiver holds off while words keep coming
    set_regs(16'h0000, 24'hFFFFFF, 24'd1);
    send_idling = 1'b0;
    hold_req = hold_req + 1;
    run_frames(100, 2);

    for (int ph = 0; ph < 4; ph++) begin
      set_regs(16'($urandom_range(16'hFFFF)), 24'($urandom_range(24'hFFFFFF, 1)),
               24'($urandom_range(24'hFFFFFF, 1)));
      send_idling = (ph != 1);
      recv_idling = (ph != 2);
      run_frames(100, (ph == 3) ? 10 : 2);
    end

    // key swapped mid-frame only
    apb_write(ckpe_pkg::ADDR_KEY_CODE, {16'd0, 16'(($urandom_range(16'hFFFF)))});
    send_idling = 1'b1;
    recv_idling = 1'b1;
    run_frames(80, 1);

    repeat (10) @(posedge clk);
    if (expected_pulses.size() != 0) begin
      mismatches++;
      $display("%0t: %0d pulses never arrived", $time, expected_pulses.size());
    end
    if (mismatches == 0) begin
      $display("tb_contact_key_pulse_encoder OK");
    end else begin
      $display("tb_contact_key_pulse_encoder NOT OK");
    end
    $finish;
  end

endmodule
